// ===== hdl/fpos_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed predictor order select package
// Shared widths, constants and the word type that travels down the cell row.
// ----------------------------------------------------------------------------
package fpos_pkg;

  // Port width of the sample field and the bits of it that are used.
  localparam int SAMPLE_W    = 24;
  localparam int SAMPLE_BITS = 24;

  // Largest block length that the sums are sized for.
  localparam int MAX_BLOCK   = 65536;

  // A fourth difference spans four more bits than the sample.
  localparam int DIFF_W      = SAMPLE_BITS + 4;

  // Sum width, fixed by the result fields.
  localparam int SUM_W       = 44;

  // Orders 0 to 4, one cell per order.
  localparam int NUM_ORDERS  = 5;
  localparam int ORDER_W     = 3;

  // Command codes.
  localparam logic CMD_HISTORY = 1'b0;
  localparam logic CMD_BLOCK   = 1'b1;

  // Word passed from one cell to the next.
  typedef struct packed {
    logic                                valid;
    logic                                block;
    logic                                last;
    logic signed [DIFF_W-1:0]            diff;
    logic [NUM_ORDERS-1:0][SUM_W-1:0]    sums;
    logic [SUM_W-1:0]                    best_sum;
    logic [ORDER_W-1:0]                  best_order;
  } item_t;

endpackage

// ===== hdl/fpos_in_if.sv =====
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one audio sample word.
// ----------------------------------------------------------------------------
interface fpos_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [fpos_pkg::SAMPLE_W-1:0] sample;
  logic                                last;

  modport source (output valid, output command, output sample, output last, input ready);
  modport sink   (input valid, input command, input sample, input last, output ready);
endinterface

// ===== hdl/fpos_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the chosen order and the five sums.
// ----------------------------------------------------------------------------
interface fpos_out_if;
  logic                          valid;
  logic                          ready;
  logic [fpos_pkg::ORDER_W-1:0]  best_order;
  logic [fpos_pkg::SUM_W-1:0]    sum_order0;
  logic [fpos_pkg::SUM_W-1:0]    sum_order1;
  logic [fpos_pkg::SUM_W-1:0]    sum_order2;
  logic [fpos_pkg::SUM_W-1:0]    sum_order3;
  logic [fpos_pkg::SUM_W-1:0]    sum_order4;

  modport source (output valid, output best_order, output sum_order0, output sum_order1,
                  output sum_order2, output sum_order3, output sum_order4, input ready);
  modport sink   (input valid, input best_order, input sum_order0, input sum_order1,
                  input sum_order2, input sum_order3, input sum_order4, output ready);
endinterface

// ===== hdl/fpos_cell.sv =====
// ----------------------------------------------------------------------------
// Order cell
// Holds the history and the error sum of one difference order. It forms the
// next higher difference for its neighbor, accumulates its absolute error
// and, on the last block word, folds its sum into the running minimum.
// ----------------------------------------------------------------------------
module fpos_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [fpos_pkg::ORDER_W-1:0]   idx,
  input  fpos_pkg::item_t                item_in,
  output fpos_pkg::item_t                item_out
);

  logic signed [fpos_pkg::DIFF_W-1:0] hist;
  logic [fpos_pkg::SUM_W-1:0]         sum;
  logic [fpos_pkg::DIFF_W-1:0]        mag;
  logic [fpos_pkg::SUM_W:0]           sum_wide;
  logic [fpos_pkg::SUM_W-1:0]         sum_sat;
  fpos_pkg::item_t                    item_next;
  fpos_pkg::item_t                    item_q;

  // Absolute value of this order's difference and saturating accumulate.
  always_comb begin
    mag      = item_in.diff[fpos_pkg::DIFF_W-1] ? fpos_pkg::DIFF_W'(-item_in.diff)
                                                : fpos_pkg::DIFF_W'(item_in.diff);
    sum_wide = {1'b0, sum} + (fpos_pkg::SUM_W + 1)'(mag);
    sum_sat  = sum_wide[fpos_pkg::SUM_W] ? '1 : sum_wide[fpos_pkg::SUM_W-1:0];
  end

  // Word for the neighbor: next difference, captured sum, running minimum.
  always_comb begin
    item_next      = item_in;
    item_next.diff = item_in.diff - hist;
    if (item_in.block == fpos_pkg::CMD_BLOCK && item_in.last) begin
      item_next.sums[idx] = sum_sat;
      // Ties go to the higher order, so an equal sum replaces the best.
      if (idx == '0 || sum_sat <= item_in.best_sum) begin
        item_next.best_sum   = sum_sat;
        item_next.best_order = idx;
      end
    end
  end

  // Cell state and the register toward the neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q.valid <= 1'b0;
      hist         <= '0;
      sum          <= '0;
    end else if (en) begin
      item_q <= item_next;
      if (item_in.valid) begin
        hist <= item_in.diff;
        if (item_in.block == fpos_pkg::CMD_BLOCK) begin
          sum <= item_in.last ? '0 : sum_sat;
        end
      end
    end
  end

  assign item_out = item_q;

endmodule

// ===== hdl/fixed_predictor_order_select_top.sv =====
// ----------------------------------------------------------------------------
// Fixed predictor order select, top level
// Picks the fixed polynomial predictor order with the smallest absolute
// residual sum over a block of audio samples.
// ----------------------------------------------------------------------------
// Usage:
//   samples: one word per sample. command selects a history sample, which
//   only primes the difference cascade, or a block sample, which also adds
//   the absolute differences of orders 0 to 4 into five sums. last on a
//   block sample closes the block; last on a history sample is ignored.
//   results: one word per closed block with the best order (ties go to the
//   higher order) and all five sums. Sums clear after each block, while the
//   difference history carries over into the next block.
// Timing:
//   A row of five cells, one per order, each one register deep, then an
//   output register. One sample is accepted every cycle while the row
//   is not stalled.
// Reset and stall:
//   rst clears the history, the sums and all valid flags. When a result
//   waits on the output and the receiver is not ready, the row holds only
//   if another result has reached its end; otherwise samples keep flowing.
// ----------------------------------------------------------------------------
module fixed_predictor_order_select_top (
  input  logic       clk,
  input  logic       rst,
  fpos_in_if.sink    samples,
  fpos_out_if.source results
);

  fpos_pkg::item_t                                           items [0:fpos_pkg::NUM_ORDERS];
  logic                                                      en;
  logic                                                      tail_result;
  logic                                                      res_valid;
  logic [fpos_pkg::ORDER_W-1:0]                              res_order;
  logic [fpos_pkg::NUM_ORDERS-1:0][fpos_pkg::SUM_W-1:0]      res_sums;

  // The row stalls only when a finished result cannot move into the output.
  assign tail_result = items[fpos_pkg::NUM_ORDERS].valid
                       && items[fpos_pkg::NUM_ORDERS].block == fpos_pkg::CMD_BLOCK
                       && items[fpos_pkg::NUM_ORDERS].last;
  assign en            = !(tail_result && res_valid && !results.ready);
  assign samples.ready = en;

  // Entry word: the sample itself is the order 0 difference.
  always_comb begin
    items[0]       = '0;
    items[0].valid = samples.valid;
    items[0].block = samples.command;
    items[0].last  = samples.last;
    items[0].diff  = fpos_pkg::DIFF_W'(signed'(samples.sample[fpos_pkg::SAMPLE_BITS-1:0]));
  end

  // Row of order cells.
  for (genvar k = 0; k < fpos_pkg::NUM_ORDERS; k++) begin : g_cell
    fpos_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .idx      (fpos_pkg::ORDER_W'(k)),
      .item_in  (items[k]),
      .item_out (items[k+1])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en && tail_result) begin
      res_order <= items[fpos_pkg::NUM_ORDERS].best_order;
      res_sums  <= items[fpos_pkg::NUM_ORDERS].sums;
    end
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en && tail_result) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign results.valid      = res_valid;
  assign results.best_order = res_order;
  assign results.sum_order0 = res_sums[0];
  assign results.sum_order1 = res_sums[1];
  assign results.sum_order2 = res_sums[2];
  assign results.sum_order3 = res_sums[3];
  assign results.sum_order4 = res_sums[4];

`ifndef SYNTH
  // The chosen order is always one of the five orders.
  a_order_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_order < fpos_pkg::ORDER_W'(fpos_pkg::NUM_ORDERS))
    else $error("best order out of range");

  // Input back-pressure only comes from a result waiting on the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> (res_valid && !results.ready && tail_result))
    else $error("row stalled without a waiting result");

  // A stall keeps the held result on the output in the next cycle.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |=> res_valid)
    else $error("result lost during stall");

  // The reported order's sum is no larger than any other sum.
  a_best_min: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_sums[res_order] <= res_sums[0] && res_sums[res_order] <= res_sums[1]
                  && res_sums[res_order] <= res_sums[2] && res_sums[res_order] <= res_sums[3]
                  && res_sums[res_order] <= res_sums[4])
    else $error("best order does not hold the smallest sum");
`endif

endmodule
